>>> sv/bezier_curve_point_generator_assert.svh
// Assertion macros for the Bezier point generator.
// They expect clk and arst_n in the scope where they are used.
`ifndef BEZIER_CURVE_POINT_GENERATOR_ASSERT_SVH
`define BEZIER_CURVE_POINT_GENERATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCPG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bcpg_pkg.sv
package bcpg_pkg;

	// field widths
	localparam int unsigned COORD_W = 32;
	localparam int unsigned ID_W    = 16;
	localparam int unsigned NC_W    = 3;
	localparam int unsigned CFG_W   = 7;

	localparam logic [CFG_W-1:0] CFG_RESET      = 7'd16;
	localparam int unsigned      MAX_POINTS_DEF = 64;

	// control point counts
	localparam logic [NC_W-1:0] NC_QUAD  = 3'd3;
	localparam logic [NC_W-1:0] NC_CUBIC = 3'd4;

	// t and 1-t are Q1.16, up to 1.0 inclusive
	localparam int unsigned   Q_W     = 17;
	localparam logic [Q_W-1:0] ONE_Q16 = 17'h1_0000;

	// restoring division of 1.0 by the segment count: one bit per cycle
	localparam logic [4:0] DIV_TOP = 5'd16;

	// multiplier: 17 x 49 unsigned, Bernstein weights are 49 bits (sum 2^48)
	localparam int unsigned MA_W = 17;
	localparam int unsigned W_W  = 49;
	localparam int unsigned P_W  = MA_W + W_W;

	// blend accumulator, preloaded with one half LSB of the Q16.16 result
	localparam int unsigned       ACC_W      = 81;
	localparam logic [ACC_W-1:0] ROUND_INIT = 81'(1) << 47;

	// sequencer steps: one product issued per step, consumed on the next
	localparam logic [4:0] STEP_MT_MT  = 5'd0;
	localparam logic [4:0] STEP_T_T    = 5'd1;
	localparam logic [4:0] STEP_MT_MT2 = 5'd2;
	localparam logic [4:0] STEP_T_MT2  = 5'd3;
	localparam logic [4:0] STEP_MT_T2  = 5'd4;
	localparam logic [4:0] STEP_T_T2   = 5'd5;
	localparam logic [4:0] STEP_MT_T   = 5'd6;
	localparam logic [4:0] STEP_BLEND  = 5'd7;
	localparam logic [4:0] STEP_DONE   = 5'd23;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_CALC = 5'b00100,
		S_EMIT = 5'b01000,
		S_LAST = 5'b10000
	} state_t;

	typedef struct packed {
		logic [NC_W-1:0]          n_controls;
		logic signed [COORD_W-1:0] x0;
		logic signed [COORD_W-1:0] x1;
		logic signed [COORD_W-1:0] x2;
		logic signed [COORD_W-1:0] x3;
		logic signed [COORD_W-1:0] y0;
		logic signed [COORD_W-1:0] y1;
		logic signed [COORD_W-1:0] y2;
		logic signed [COORD_W-1:0] y3;
		logic [ID_W-1:0]          path_id;
	} curve_beat_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [ID_W-1:0]          out_path_id;
		logic                     last_point;
		logic                     bad_curve;
	} point_beat_t;

	// control coordinate k of x (coord_y low) or y, offset to unsigned
	function automatic logic [COORD_W-1:0] pick_biased(curve_beat_t c, logic coord_y,
			logic [1:0] k);
		logic [COORD_W-1:0] v;
		case ({coord_y, k})
			3'b000:  v = c.x0;
			3'b001:  v = c.x1;
			3'b010:  v = c.x2;
			3'b011:  v = c.x3;
			3'b100:  v = c.y0;
			3'b101:  v = c.y1;
			3'b110:  v = c.y2;
			default: v = c.y3;
		endcase
		return {~v[COORD_W-1], v[COORD_W-2:0]};
	endfunction

endpackage

>>> sv/bezier_curve_point_generator.sv
// Channel  Handshake                  Payload                          Beats per curve
// curve    curve_valid / curve_stall  bcpg_pkg::curve_beat_t curve     one
// point    point_valid / point_stall  bcpg_pkg::point_beat_t point     point_count, or one
// config   cfg_we                     cfg_data (point_count)           any time idle
//
// A good curve first divides 1.0 by the segment count, then computes each interior point
// (23 products through the one 17x49 multiplier, plus drain and emit), then emits the
// endpoint; a bad curve or a point count of one goes straight to the endpoint beat.
// curve_stall is high from acceptance until the final beat is loaded into the output
// register; that beat may then wait on point_stall while the next curve is taken.
// arst_n clears the sequencer, the output valid and sets point_count to 16.
module bezier_curve_point_generator #(
	parameter int unsigned MAX_POINTS = bcpg_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bcpg_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          curve_valid,
	output logic                          curve_stall,
	input  bcpg_pkg::curve_beat_t         curve,
	output logic                          point_valid,
	input  logic                          point_stall,
	output bcpg_pkg::point_beat_t         point
);

	`include "bezier_curve_point_generator_assert.svh"

	localparam int unsigned SEG_W = $clog2(MAX_POINTS);
	localparam int unsigned CFG_W = bcpg_pkg::CFG_W;
	localparam int unsigned Q_W   = bcpg_pkg::Q_W;
	localparam int unsigned W_W   = bcpg_pkg::W_W;
	localparam int unsigned P_W   = bcpg_pkg::P_W;
	localparam int unsigned ACC_W = bcpg_pkg::ACC_W;
	localparam int unsigned CW    = bcpg_pkg::COORD_W;

	// control state
	bcpg_pkg::state_t   state_q;
	logic [4:0]         step_q;
	logic [4:0]         div_cnt_q;
	logic [SEG_W-1:0]   i_q;
	logic [SEG_W-1:0]   seg_q;
	logic [CFG_W-1:0]   point_count_q;
	logic               bad_q;
	logic               point_valid_q;

	// datapath
	bcpg_pkg::curve_beat_t cur_q;
	bcpg_pkg::point_beat_t point_q;
	logic [Q_W-1:0]     q0_q;
	logic [SEG_W-1:0]   div_rem_q;
	logic [SEG_W-1:0]   rem_q;
	logic [Q_W-1:0]     t_q;
	logic [P_W-1:0]     prod_q;
	logic [33:0]        mt2_q;
	logic [32:0]        t2_q;
	logic [W_W-1:0]     w_q [4];
	logic [ACC_W-1:0]   acc_q;
	logic [CW-1:0]      res_x_q;
	logic [CW-1:0]      res_y_q;

	logic               curve_acc;
	logic               out_free;
	logic               load_pt;
	logic               nc_ok;
	logic [CFG_W-1:0]   count_c;
	logic [CFG_W-1:0]   seg_c;
	logic [Q_W-1:0]     mt;

	// point count clamp: zero acts as one, above the maximum saturates
	always_comb begin
		if (point_count_q == '0) begin
			count_c = CFG_W'(1);
		end else if (point_count_q > CFG_W'(MAX_POINTS)) begin
			count_c = CFG_W'(MAX_POINTS);
		end else begin
			count_c = point_count_q;
		end
		seg_c = count_c - CFG_W'(1);
	end

	assign nc_ok = (curve.n_controls == bcpg_pkg::NC_QUAD) ||
		(curve.n_controls == bcpg_pkg::NC_CUBIC);
	assign curve_stall = (state_q != bcpg_pkg::S_IDLE);
	assign curve_acc   = curve_valid && !curve_stall;
	assign out_free    = !point_valid_q || !point_stall;
	assign load_pt     = out_free &&
		((state_q == bcpg_pkg::S_EMIT) || (state_q == bcpg_pkg::S_LAST));
	assign mt          = bcpg_pkg::ONE_Q16 - t_q;

	// restoring divide of 2^16 by the segment count, MSB first
	logic               div_bit;
	logic [SEG_W:0]     div_sh;
	logic               div_ge;
	logic [SEG_W:0]     div_sub;

	assign div_bit = (div_cnt_q == bcpg_pkg::DIV_TOP);
	assign div_sh  = {div_rem_q, div_bit};
	assign div_ge  = div_sh >= {1'b0, seg_q};
	assign div_sub = div_sh - {1'b0, seg_q};

	// next t: t += q0, plus one when the running remainder wraps
	logic [SEG_W:0]     rem_sum;
	logic               rem_carry;
	logic [SEG_W:0]     rem_wrap;
	logic [Q_W-1:0]     t_next;

	assign rem_sum   = {1'b0, rem_q} + {1'b0, div_rem_q};
	assign rem_carry = rem_sum >= {1'b0, seg_q};
	assign rem_wrap  = rem_sum - {1'b0, seg_q};
	assign t_next    = t_q + q0_q + Q_W'(rem_carry);

	// multiplier operand selection for the product issued this step
	logic [4:0]         iss_j;
	logic [CW-1:0]      iss_ctl;
	logic [Q_W-1:0]     mul_a;
	logic [W_W-1:0]     mul_b;

	assign iss_j   = step_q - bcpg_pkg::STEP_BLEND;
	assign iss_ctl = bcpg_pkg::pick_biased(cur_q, iss_j[3], iss_j[2:1]);

	always_comb begin
		case (step_q) inside
			bcpg_pkg::STEP_MT_MT: begin
				mul_a = mt;
				mul_b = W_W'(mt);
			end
			bcpg_pkg::STEP_T_T: begin
				mul_a = t_q;
				mul_b = W_W'(t_q);
			end
			bcpg_pkg::STEP_MT_MT2: begin
				mul_a = mt;
				mul_b = W_W'(mt2_q);
			end
			bcpg_pkg::STEP_T_MT2: begin
				mul_a = t_q;
				mul_b = W_W'(mt2_q);
			end
			bcpg_pkg::STEP_MT_T2: begin
				mul_a = mt;
				mul_b = W_W'(t2_q);
			end
			bcpg_pkg::STEP_T_T2: begin
				mul_a = t_q;
				mul_b = W_W'(t2_q);
			end
			bcpg_pkg::STEP_MT_T: begin
				mul_a = mt;
				mul_b = W_W'(t_q);
			end
			[bcpg_pkg::STEP_BLEND : bcpg_pkg::STEP_DONE - 5'd1]: begin
				// high half of the offset coordinate first, then low half
				mul_a = iss_j[0] ? Q_W'(iss_ctl[15:0]) : Q_W'(iss_ctl[CW-1:16]);
				mul_b = w_q[iss_j[2:1]];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// blend accumulate for the product consumed this step
	logic [4:0]         con_j;
	logic [ACC_W-1:0]   acc_base;
	logic [ACC_W-1:0]   acc_add;
	logic [ACC_W-1:0]   acc_next;
	logic [W_W-1:0]     prod_x3;

	assign con_j    = step_q - (bcpg_pkg::STEP_BLEND + 5'd1);
	assign acc_base = (con_j[2:0] == 3'd0) ? bcpg_pkg::ROUND_INIT : acc_q;
	assign acc_add  = con_j[0] ? {16'b0, prod_q[64:0]} : {prod_q[64:0], 16'b0};
	assign acc_next = acc_base + acc_add;
	assign prod_x3  = prod_q[W_W-1:0] + {prod_q[W_W-2:0], 1'b0};

	// output beat assembly
	bcpg_pkg::point_beat_t point_nx;

	always_comb begin
		point_nx.out_path_id = cur_q.path_id;
		if (state_q == bcpg_pkg::S_EMIT) begin
			point_nx.point_x    = res_x_q;
			point_nx.point_y    = res_y_q;
			point_nx.last_point = 1'b0;
			point_nx.bad_curve  = 1'b0;
		end else if (bad_q) begin
			point_nx.point_x    = '0;
			point_nx.point_y    = '0;
			point_nx.last_point = 1'b1;
			point_nx.bad_curve  = 1'b1;
		end else begin
			// endpoint is the last control point exactly
			point_nx.point_x    = (cur_q.n_controls == bcpg_pkg::NC_QUAD) ? cur_q.x2 : cur_q.x3;
			point_nx.point_y    = (cur_q.n_controls == bcpg_pkg::NC_QUAD) ? cur_q.y2 : cur_q.y3;
			point_nx.last_point = 1'b1;
			point_nx.bad_curve  = 1'b0;
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= bcpg_pkg::CFG_RESET;
		end else if (cfg_we) begin
			point_count_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bcpg_pkg::S_IDLE;
			step_q    <= '0;
			div_cnt_q <= '0;
			i_q       <= '0;
			seg_q     <= '0;
			bad_q     <= 1'b0;
		end else begin
			case (state_q)
				bcpg_pkg::S_IDLE: begin
					if (curve_acc) begin
						seg_q     <= seg_c[SEG_W-1:0];
						bad_q     <= !nc_ok;
						div_cnt_q <= bcpg_pkg::DIV_TOP;
						if (!nc_ok || (seg_c == '0)) begin
							state_q <= bcpg_pkg::S_LAST;
						end else begin
							state_q <= bcpg_pkg::S_DIV;
						end
					end
				end
				bcpg_pkg::S_DIV: begin
					div_cnt_q <= div_cnt_q - 5'd1;
					if (div_cnt_q == '0) begin
						state_q <= bcpg_pkg::S_CALC;
						step_q  <= '0;
						i_q     <= '0;
					end
				end
				bcpg_pkg::S_CALC: begin
					step_q <= step_q + 5'd1;
					if (step_q == bcpg_pkg::STEP_DONE) begin
						state_q <= bcpg_pkg::S_EMIT;
					end
				end
				bcpg_pkg::S_EMIT: begin
					if (out_free) begin
						step_q <= '0;
						if (i_q == seg_q - SEG_W'(1)) begin
							state_q <= bcpg_pkg::S_LAST;
						end else begin
							i_q     <= i_q + SEG_W'(1);
							state_q <= bcpg_pkg::S_CALC;
						end
					end
				end
				bcpg_pkg::S_LAST: begin
					if (out_free) begin
						state_q <= bcpg_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= bcpg_pkg::S_IDLE;
				end
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_valid_q <= 1'b0;
		end else if (load_pt) begin
			point_valid_q <= 1'b1;
		end else if (!point_stall) begin
			point_valid_q <= 1'b0;
		end
	end

	// curve capture, divider and t stepping
	always_ff @(posedge clk) begin
		if (curve_acc) begin
			cur_q     <= curve;
			div_rem_q <= '0;
			q0_q      <= '0;
		end
		if (state_q == bcpg_pkg::S_DIV) begin
			div_rem_q <= div_ge ? div_sub[SEG_W-1:0] : div_sh[SEG_W-1:0];
			q0_q      <= {q0_q[Q_W-2:0], div_ge};
			t_q       <= '0;
			rem_q     <= '0;
		end
		if ((state_q == bcpg_pkg::S_EMIT) && out_free) begin
			t_q   <= t_next;
			rem_q <= rem_carry ? rem_wrap[SEG_W-1:0] : rem_sum[SEG_W-1:0];
		end
		if (load_pt) begin
			point_q <= point_nx;
		end
	end

	// shared multiplier and consumers of its registered product
	always_ff @(posedge clk) begin
		prod_q <= P_W'(mul_a) * P_W'(mul_b);
		if (state_q == bcpg_pkg::S_CALC) begin
			case (step_q) inside
				bcpg_pkg::STEP_MT_MT + 5'd1: begin
					mt2_q <= prod_q[33:0];
					if (cur_q.n_controls == bcpg_pkg::NC_QUAD) begin
						w_q[0] <= {prod_q[32:0], 16'b0};
					end
				end
				bcpg_pkg::STEP_T_T + 5'd1: begin
					t2_q <= prod_q[32:0];
					if (cur_q.n_controls == bcpg_pkg::NC_QUAD) begin
						w_q[2] <= {prod_q[32:0], 16'b0};
						w_q[3] <= '0;
					end
				end
				bcpg_pkg::STEP_MT_MT2 + 5'd1: begin
					if (cur_q.n_controls == bcpg_pkg::NC_CUBIC) begin
						w_q[0] <= prod_q[W_W-1:0];
					end
				end
				bcpg_pkg::STEP_T_MT2 + 5'd1: begin
					if (cur_q.n_controls == bcpg_pkg::NC_CUBIC) begin
						w_q[1] <= prod_x3;
					end
				end
				bcpg_pkg::STEP_MT_T2 + 5'd1: begin
					if (cur_q.n_controls == bcpg_pkg::NC_CUBIC) begin
						w_q[2] <= prod_x3;
					end
				end
				bcpg_pkg::STEP_T_T2 + 5'd1: begin
					if (cur_q.n_controls == bcpg_pkg::NC_CUBIC) begin
						w_q[3] <= prod_q[W_W-1:0];
					end
				end
				bcpg_pkg::STEP_MT_T + 5'd1: begin
					if (cur_q.n_controls == bcpg_pkg::NC_QUAD) begin
						w_q[1] <= {prod_q[31:0], 17'b0};
					end
				end
				[bcpg_pkg::STEP_BLEND + 5'd1 : bcpg_pkg::STEP_DONE]: begin
					acc_q <= acc_next;
					// result is bits 79:48 after rounding, offset removed
					if (con_j[3:0] == 4'd7) begin
						res_x_q <= {~acc_next[79], acc_next[78:48]};
					end
					if (con_j[3:0] == 4'd15) begin
						res_y_q <= {~acc_next[79], acc_next[78:48]};
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign point_valid = point_valid_q;
	assign point       = point_q;

	// checks
	`BCPG_ASSERT_NOW(a_rem_below_seg,
		(state_q == bcpg_pkg::S_CALC) || (state_q == bcpg_pkg::S_EMIT),
		rem_q < seg_q, "t remainder reached the segment count")
	`BCPG_ASSERT_NOW(a_index_below_seg,
		(state_q == bcpg_pkg::S_CALC) || (state_q == bcpg_pkg::S_EMIT),
		i_q < seg_q, "point index ran past the last interior point")
	`BCPG_ASSERT_NOW(a_bad_is_last, point_valid && point.bad_curve,
		point.last_point, "bad curve beat without last flag")
	`BCPG_ASSERT_NEXT(a_curve_busy, curve_valid && !curve_stall,
		(state_q == bcpg_pkg::S_DIV) || (state_q == bcpg_pkg::S_LAST),
		"accepted curve did not start work")

endmodule
